// ===== src/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants for the wildcard byte pattern scanner: field widths,
// configuration register indexes, result status codes and the default pattern depth.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;

	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 48;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W     = 5;
	localparam int SKIP_W    = 16;
	localparam int WILD_W    = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP    = 3'd4;

	// result status codes
	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

endpackage

// ===== src/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Scans addressed bytes for a wildcard pattern with a chain of window cells,
// counts off skipped matches and reports the next match or not-found.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, also while a result waits in the output
//   register as long as out_ready takes it in the same cycle.
// The result is registered and shown in the cycle after the byte that causes it.
// The cell chain and the skip counter update in the cycle of each transfer.
// Reset clears the cells, counters, configuration and the output valid flag.
module wildcard_byte_pattern_scanner #(
	parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wbps_pkg::CFG_W-1:0]     cfg_wdata,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wbps_pkg::BYTE_W-1:0]    data_byte,
	input  logic [wbps_pkg::ADDR_W-1:0]    byte_address,
	input  logic                          region_start,
	input  logic                          scan_start,
	input  logic                          scan_end,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [wbps_pkg::ADDR_W-1:0]    match_address
);

	localparam int BW = wbps_pkg::BYTE_W;

	logic [wbps_pkg::CFG_W-1:0]  pat_lo_q;
	logic [wbps_pkg::CFG_W-1:0]  pat_hi_q;
	logic [wbps_pkg::WILD_W-1:0] wild_q;
	logic [wbps_pkg::LEN_W-1:0]  len_q;
	logic [wbps_pkg::SKIP_W-1:0] skip_cfg_q;

	logic [wbps_pkg::SKIP_W-1:0] skips_q;
	logic                        fin_q;
	logic                        out_valid_q;
	logic                        status_q;
	logic [wbps_pkg::ADDR_W-1:0] addr_q;

	logic [2*wbps_pkg::CFG_W-1:0]       pat_all;
	logic [MAX_PATTERN-1:0][BW-1:0]     byte_q;
	logic [MAX_PATTERN-1:0][BW-1:0]     byte_in;
	logic [MAX_PATTERN-1:0][BW-1:0]     pat_sel;
	logic [MAX_PATTERN-1:0]             seen_q;
	logic [MAX_PATTERN-1:0]             seen_in;
	logic [MAX_PATTERN-1:0]             wild_sel;
	logic [MAX_PATTERN-1:0]             hit;
	logic                               accept;
	logic                               clear;
	logic                               match;
	logic [wbps_pkg::SKIP_W-1:0]        skips_eff;
	logic                               fin_eff;
	logic                               give_found;
	logic                               give_end;

	assign pat_all = {pat_hi_q, pat_lo_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q   <= '0;
			pat_hi_q   <= '0;
			wild_q     <= '0;
			len_q      <= '0;
			skip_cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wbps_pkg::REG_PAT_LO: pat_lo_q   <= cfg_wdata;
				wbps_pkg::REG_PAT_HI: pat_hi_q   <= cfg_wdata;
				wbps_pkg::REG_WILD:   wild_q     <= cfg_wdata[wbps_pkg::WILD_W-1:0];
				wbps_pkg::REG_LEN:    len_q      <= cfg_wdata[wbps_pkg::LEN_W-1:0];
				wbps_pkg::REG_SKIP:   skip_cfg_q <= cfg_wdata[wbps_pkg::SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	// take a byte whenever the output register is free or drains this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign clear    = region_start || scan_start;

	// line up pattern byte len-1-k with the byte k positions back
	always_comb begin
		pat_sel  = '0;
		wild_sel = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			for (int p = 0; p < MAX_PATTERN; p++) begin
				if (len_q == wbps_pkg::LEN_W'(k + p + 1)) begin
					pat_sel[k]  = pat_all[BW*p +: BW];
					wild_sel[k] = wild_q[p];
				end
			end
		end
	end

	// window cell chain: cell k compares the byte k positions back and holds it after the transfer
	genvar j;
	generate
		for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
			if (j == 0) begin : g_head
				assign byte_in[j] = data_byte;
				assign seen_in[j] = 1'b1;
			end else begin : g_body
				assign byte_in[j] = byte_q[j-1];
				assign seen_in[j] = seen_q[j-1] & ~clear;
			end
			wbps_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (accept),
				.byte_in  (byte_in[j]),
				.seen_in  (seen_in[j]),
				.pat_byte (pat_sel[j]),
				.wild     (wild_sel[j]),
				.hit      (hit[j]),
				.byte_q   (byte_q[j]),
				.seen_q   (seen_q[j])
			);
		end
	endgenerate

	// all cells inside the pattern length must hit
	always_comb begin
		match = (len_q != '0) && (len_q <= wbps_pkg::LEN_W'(MAX_PATTERN));
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (len_q > wbps_pkg::LEN_W'(k)) begin
				match = match && hit[k];
			end
		end
	end

	// skip counting and result decision
	always_comb begin
		skips_eff  = scan_start ? skip_cfg_q : skips_q;
		fin_eff    = scan_start ? 1'b0 : fin_q;
		give_found = !fin_eff && match && (skips_eff == '0);
		give_end   = !fin_eff && !give_found && scan_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skips_q <= '0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			fin_q <= fin_eff || give_found || give_end;
			if (!fin_eff && match && (skips_eff != '0)) begin
				skips_q <= skips_eff - 1'b1;
			end else begin
				skips_q <= skips_eff;
			end
		end
	end

	// output register: load on a result, drop on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (give_found || give_end)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (give_found || give_end)) begin
			status_q <= give_found ? wbps_pkg::STATUS_FOUND : wbps_pkg::STATUS_NOT_FOUND;
			addr_q   <= give_found
				? byte_address - wbps_pkg::ADDR_W'(len_q - 1'b1)
				: '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign match_address = addr_q;

endmodule

// ===== src/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// wbps_cell
// One cell of the byte window chain. The cell holds one window byte and a
// flag that the byte belongs to the current region, takes the byte of its
// left neighbor on each transfer and compares the byte it takes with the
// pattern byte that lines up with its position.
// ----------------------------------------------------------------------------
module wbps_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [wbps_pkg::BYTE_W-1:0] byte_in,
	input  logic                        seen_in,
	input  logic [wbps_pkg::BYTE_W-1:0] pat_byte,
	input  logic                        wild,
	output logic                        hit,
	output logic [wbps_pkg::BYTE_W-1:0] byte_q,
	output logic                        seen_q
);

	// compare the incoming window byte, only inside the region
	assign hit = seen_in & (wild | (byte_in == pat_byte));

	// hold the window byte, advance on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			seen_q <= 1'b0;
		end else if (advance) begin
			byte_q <= byte_in;
			seen_q <= seen_in;
		end
	end

endmodule

// ===== src/wbps_checker.sv =====
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks for the wildcard byte pattern scanner, bound to the top.
// ----------------------------------------------------------------------------
module wbps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          status,
	input logic [wbps_pkg::ADDR_W-1:0]    match_address
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(match_address))
		else $error("result changed while stalled");

	// not-found results carry a zero address
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == wbps_pkg::STATUS_NOT_FOUND) |-> (match_address == '0))
		else $error("not-found result with nonzero address");

	// a new result only follows an input transfer
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an input transfer");

	// a drained result with no new byte leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared without cause");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
